[hdl/cffspq_pkg.sv]
package cffspq_pkg;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] priority_req;
    logic [63:0] packet_data;
  } cffspq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] packet_out;
    logic [5:0]  bucket_index;
    logic [31:0] base_priority;
  } cffspq_rsp_t;

endpackage

[hdl/circular_ffs_priority_queue_core.sv]
// Circular bucketed priority queue with two halves of BUCKETS buckets,
// each bucket a FIFO of 2**FIFO_SHIFT 64-bit descriptors. An enqueue
// result is loaded into the output register in state S_PTR, which follows
// acceptance; a dequeue result is loaded in state S_DATA, after the
// descriptor store is read in S_PTR, or in S_PTR if the queue is empty.
// Both wait while the output register holds an unread result. The FIFO
// pointer memory and the descriptor store both have registered reads. One
// request is worked on at a time; a new one is taken as soon as the
// previous one has moved its result into the output register. The
// pointer memory has one valid bit per FIFO that reset clears, so the
// block is ready right after reset with no clearing pass. The window base
// is reported with every result.
module circular_ffs_priority_queue_core #(
  parameter int unsigned BUCKETS    = 64,
  parameter int unsigned FIFO_SHIFT = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  cffspq_pkg::cffspq_req_t  in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output cffspq_pkg::cffspq_rsp_t  out_rsp_o
);
  import cffspq_pkg::*;

  localparam int unsigned FIFOS = 2 * BUCKETS;
  localparam int unsigned FW    = $clog2(FIFOS);
  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned PW    = FIFO_SHIFT + 1;
  localparam int unsigned CAP   = 1 << FIFO_SHIFT;
  localparam int unsigned DEPTH = FIFOS << FIFO_SHIFT;
  localparam int unsigned AW    = FW + FIFO_SHIFT;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [1:0][BUCKETS-1:0]     bitmap_q, bitmap_d;
  logic                        prim_q, prim_d;
  logic [31:0]                 base_q, base_d;
  logic                        mode_q;
  logic                        empty_q;
  logic                        half_q;
  logic [BW-1:0]               bucket_q;
  logic [FW-1:0]               fifo_q;
  logic [63:0]                 data_q;

  logic [2*PW-1:0]             ptr_mem [FIFOS];
  logic [FIFOS-1:0]            ptr_vld_q;
  logic [2*PW-1:0]             ptr_rdata_q;
  logic                        ptr_rvld_q;
  logic [63:0]                 store_mem [DEPTH];
  logic [63:0]                 store_rdata_q;

  logic                        out_valid_q;
  cffspq_rsp_t                 out_q;

  // request decode at acceptance
  logic                        accept;
  logic [32:0]                 diff;
  logic                        below, above, in_sec;
  logic [FW-1:0]               off, off_sub;
  logic [BW-1:0]               enq_bucket, ffs_bucket, sel_bucket;
  logic                        enq_half, deq_half, sel_half;
  logic                        prim_empty, other_empty, deq_empty, deq_swap;
  logic [BUCKETS-1:0]          deq_map;
  logic [FW-1:0]               sel_fifo;

  // pointer stage
  logic [PW-1:0]               head, tail, level, next_head, next_tail;
  logic                        full;
  logic [1:0][BUCKETS-1:0]     bm_deq;
  logic                        swap_after;
  logic                        out_space, out_load;
  logic                        ptr_we, store_we, store_re;
  logic [2*PW-1:0]             ptr_wdata;
  logic [AW-1:0]               store_waddr, store_raddr;
  cffspq_rsp_t                 rsp;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // clamp the priority into [base, base + 2*BUCKETS)
  assign diff    = {1'b0, in_req_i.priority_req} - {1'b0, base_q};
  assign below   = diff[32];
  assign above   = (diff[31:0] >= 32'(FIFOS));
  assign off     = below ? '0 : (above ? FW'(FIFOS - 1) : diff[FW-1:0]);
  assign in_sec  = (off >= FW'(BUCKETS));
  assign off_sub = off - FW'(BUCKETS);
  assign enq_bucket = in_sec ? off_sub[BW-1:0] : off[BW-1:0];
  assign enq_half   = prim_q ^ in_sec;

  assign prim_empty  = ~|bitmap_q[prim_q];
  assign other_empty = ~|bitmap_q[~prim_q];
  assign deq_empty   = prim_empty && other_empty;
  assign deq_swap    = prim_empty && !other_empty;
  assign deq_half    = prim_q ^ deq_swap;
  assign deq_map     = bitmap_q[deq_half];

  // find first set, lowest bucket wins
  always_comb begin
    ffs_bucket = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) begin
      if (deq_map[i]) begin
        ffs_bucket = BW'(i);
      end
    end
  end

  always_comb begin
    if (in_req_i.mode == MODE_ENQ) begin
      sel_half   = enq_half;
      sel_bucket = enq_bucket;
    end else begin
      sel_half   = deq_half;
      sel_bucket = deq_empty ? '0 : ffs_bucket;
    end
    sel_fifo = (sel_half ? FW'(BUCKETS) : '0) + FW'(sel_bucket);
  end

  // pointer word: head in the upper half, tail in the lower half
  assign head      = ptr_rvld_q ? ptr_rdata_q[2*PW-1:PW] : '0;
  assign tail      = ptr_rvld_q ? ptr_rdata_q[PW-1:0] : '0;
  assign level     = tail - head;
  assign full      = level[FIFO_SHIFT];
  assign next_head = head + PW'(1);
  assign next_tail = tail + PW'(1);

  always_comb begin
    bm_deq = bitmap_q;
    if (next_head == tail) begin
      bm_deq[half_q][bucket_q] = 1'b0;
    end
  end
  assign swap_after = ~|bm_deq[half_q] && |bm_deq[~half_q];

  assign out_space = !out_valid_q || out_ready_i;
  assign out_load  = out_space &&
                     (((state_q == S_PTR) && ((mode_q == MODE_ENQ) || empty_q)) ||
                      (state_q == S_DATA));

  assign store_we    = (state_q == S_PTR) && (mode_q == MODE_ENQ) && !full && out_space;
  assign store_re    = (state_q == S_PTR) && (mode_q == MODE_DEQ) && !empty_q;
  assign ptr_we      = store_we || store_re;
  assign ptr_wdata   = (mode_q == MODE_ENQ) ? {head, next_tail} : {next_head, tail};
  assign store_waddr = {fifo_q, tail[FIFO_SHIFT-1:0]};
  assign store_raddr = {fifo_q, head[FIFO_SHIFT-1:0]};

  always_comb begin
    state_d  = state_q;
    bitmap_d = bitmap_q;
    prim_d   = prim_q;
    base_d   = base_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PTR;
          if (in_req_i.mode == MODE_DEQ && deq_swap) begin
            prim_d = ~prim_q;
            base_d = base_q + 32'(BUCKETS);
          end
        end
      end
      S_PTR: begin
        if (mode_q == MODE_DEQ && !empty_q) begin
          state_d  = S_DATA;
          bitmap_d = bm_deq;
          if (swap_after) begin
            prim_d = ~prim_q;
            base_d = base_q + 32'(BUCKETS);
          end
        end else if (out_space) begin
          state_d = S_IDLE;
          if (store_we) begin
            bitmap_d[half_q][bucket_q] = 1'b1;
          end
        end
      end
      S_DATA: begin
        if (out_space) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.base_priority = base_q;
    rsp.bucket_index  = 6'(bucket_q);
    rsp.packet_out    = '0;
    if (state_q == S_DATA) begin
      rsp.status     = STATUS_OK;
      rsp.packet_out = store_rdata_q;
    end else if (mode_q == MODE_ENQ) begin
      rsp.status = full ? STATUS_FULL : STATUS_OK;
    end else begin
      rsp.status = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bitmap_q    <= '0;
      prim_q      <= 1'b0;
      base_q      <= '0;
      ptr_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bitmap_q <= bitmap_d;
      prim_q   <= prim_d;
      base_q   <= base_d;
      if (ptr_we) begin
        ptr_vld_q[fifo_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= in_req_i.mode;
      empty_q  <= (in_req_i.mode == MODE_DEQ) && deq_empty;
      half_q   <= sel_half;
      bucket_q <= sel_bucket;
      fifo_q   <= sel_fifo;
      data_q   <= in_req_i.packet_data;
    end
    if (out_load) begin
      out_q <= rsp;
    end
  end

  // fifo pointer memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ptr_rdata_q <= ptr_mem[sel_fifo];
      ptr_rvld_q  <= ptr_vld_q[sel_fifo];
    end
    if (ptr_we) begin
      ptr_mem[fifo_q] <= ptr_wdata;
    end
  end

  // descriptor store
  always_ff @(posedge clk_i) begin
    if (store_re) begin
      store_rdata_q <= store_mem[store_raddr];
    end
    if (store_we) begin
      store_mem[store_waddr] <= data_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_store_write_on_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == S_PTR) && (mode_q == MODE_ENQ))
    else $error("descriptor store written outside an enqueue");

  a_served_bucket_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) && (mode_q == MODE_DEQ) && !empty_q |-> bitmap_q[half_q][bucket_q])
    else $error("dequeue served a bucket whose occupancy bit is clear");

  a_served_fifo_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) && (mode_q == MODE_DEQ) && !empty_q |-> (level != '0))
    else $error("dequeue served an empty bucket fifo");

  a_level_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PTR) && (mode_q == MODE_ENQ) |-> (level <= PW'(CAP)))
    else $error("bucket fifo level beyond capacity");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) != S_IDLE))
    else $error("result appeared without a request in progress");
`endif

endmodule
